/* sv/assert_macros.svh */
// assertion helpers included by cipher_header_parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define CHP_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHP_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* sv/chp_pkg.sv */
`timescale 1ns / 1ps

package chp_pkg;

   typedef enum logic [2:0] {
      PH_FLAGS   = 3'd0,
      PH_KGUID   = 3'd1,
      PH_KOFF    = 3'd2,
      PH_KEYGUID = 3'd3,
      PH_OFFSET  = 3'd4,
      PH_LENGTH  = 3'd5,
      PH_ALG     = 3'd6,
      PH_DONE    = 3'd7
   } chp_phase_type;

   localparam logic [31:0] FLAG_INTERNAL     = 32'h4000_0000;
   localparam logic [31:0] FLAG_KERNEL       = 32'h2000_0000;
   localparam logic [31:0] FLAG_KEY_GUID     = 32'h1000_0000;
   localparam logic [31:0] FLAG_ALGORITHM    = 32'h0020_0000;
   localparam logic [31:0] FLAG_DECRYPT_ONCE = 32'h0080_0000;
   localparam logic [31:0] FLAG_VERIFY_KEY   = 32'h0040_0000;
   localparam logic [31:0] FLAG_END_CHAIN    = 32'h0010_0000;
   localparam logic [31:0] FLAG_TRAILER      = 32'h0000_0010;

   // size selector positions: bits 27:26 key offset, 25:24 text length
   localparam int OFFSET_SEL_LSB = 26;
   localparam int LENGTH_SEL_LSB = 24;

   localparam logic [5:0] COUNT_MAX = 6'd63;

   localparam logic STATUS_COMPLETE  = 1'b0;
   localparam logic STATUS_TRUNCATED = 1'b1;

   typedef struct packed {
      logic        status;
      logic        is_internal;
      logic [63:0] key_offset;
      logic [63:0] text_length;
      logic [7:0]  algorithm;
      logic [63:0] kernel_id_low;
      logic [63:0] kernel_id_high;
      logic [31:0] kernel_offset;
      logic [63:0] key_id_low;
      logic [63:0] key_id_high;
      logic [3:0]  option_bits;
      logic [5:0]  header_length;
   } chp_result_type;

   function automatic logic [4:0] sel_size(input logic [1:0] sel);
      logic [4:0] sz;
      case (sel)
         2'd1:    sz = 5'd2;
         2'd2:    sz = 5'd4;
         2'd3:    sz = 5'd8;
         default: sz = 5'd0;
      endcase
      return sz;
   endfunction

   // byte count of a phase under a flag word, zero when the field is absent
   function automatic logic [4:0] phase_size(input chp_phase_type ph, input logic [31:0] flags);
      logic       internal;
      logic [4:0] sz;
      internal = (flags & FLAG_INTERNAL) != 32'd0;
      case (ph)
         PH_FLAGS:   sz = 5'd4;
         PH_KGUID:   sz = (!internal && (flags & FLAG_KERNEL) != 32'd0) ? 5'd16 : 5'd0;
         PH_KOFF:    sz = (!internal && (flags & FLAG_KERNEL) != 32'd0) ? 5'd4 : 5'd0;
         PH_KEYGUID: sz = (!internal && (flags & FLAG_KEY_GUID) != 32'd0) ? 5'd16 : 5'd0;
         PH_OFFSET:  sz = internal ? 5'd0 : sel_size(flags[OFFSET_SEL_LSB +: 2]);
         PH_LENGTH:  sz = internal ? 5'd0 : sel_size(flags[LENGTH_SEL_LSB +: 2]);
         PH_ALG:     sz = (!internal && (flags & FLAG_ALGORITHM) != 32'd0) ? 5'd1 : 5'd0;
         default:    sz = 5'd0;
      endcase
      return sz;
   endfunction

   // first phase after ph that has bytes, or done
   function automatic chp_phase_type next_phase(input chp_phase_type ph,
                                                input logic [31:0] flags);
      chp_phase_type nxt;
      logic          found;
      nxt   = PH_DONE;
      found = 1'b0;
      for (int i = 1; i < 7; i++) begin
         if (!found && i > int'(ph) &&
             phase_size(chp_phase_type'(i[2:0]), flags) != 5'd0) begin
            nxt   = chp_phase_type'(i[2:0]);
            found = 1'b1;
         end
      end
      return nxt;
   endfunction

endpackage

/* sv/chp_req_if.sv */
`timescale 1ns / 1ps

interface chp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/chp_rsp_if.sv */
`timescale 1ns / 1ps

interface chp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        is_internal;
   logic [63:0] key_offset;
   logic [63:0] text_length;
   logic [7:0]  algorithm;
   logic [63:0] kernel_id_low;
   logic [63:0] kernel_id_high;
   logic [31:0] kernel_offset;
   logic [63:0] key_id_low;
   logic [63:0] key_id_high;
   logic [3:0]  option_bits;
   logic [5:0]  header_length;

   modport source (output valid, output status, output is_internal, output key_offset,
                   output text_length, output algorithm, output kernel_id_low,
                   output kernel_id_high, output kernel_offset, output key_id_low,
                   output key_id_high, output option_bits, output header_length,
                   input ready);
   modport sink   (input valid, input status, input is_internal, input key_offset,
                   input text_length, input algorithm, input kernel_id_low,
                   input kernel_id_high, input kernel_offset, input key_id_low,
                   input key_id_high, input option_bits, input header_length,
                   output ready);
endinterface

/* sv/chp_rsp_reg.sv */
`timescale 1ns / 1ps

module chp_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  chp_pkg::chp_result_type result,
   output logic                   free,
   chp_rsp_if.source              rsp_chan
);

   logic                   valid_ff;
   logic                   valid_in;
   chp_pkg::chp_result_type res_ff;

   // room for a new result when empty or when the held one leaves this cycle
   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.status         = res_ff.status;
   assign rsp_chan.is_internal    = res_ff.is_internal;
   assign rsp_chan.key_offset     = res_ff.key_offset;
   assign rsp_chan.text_length    = res_ff.text_length;
   assign rsp_chan.algorithm      = res_ff.algorithm;
   assign rsp_chan.kernel_id_low  = res_ff.kernel_id_low;
   assign rsp_chan.kernel_id_high = res_ff.kernel_id_high;
   assign rsp_chan.kernel_offset  = res_ff.kernel_offset;
   assign rsp_chan.key_id_low     = res_ff.key_id_low;
   assign rsp_chan.key_id_high    = res_ff.key_id_high;
   assign rsp_chan.option_bits    = res_ff.option_bits;
   assign rsp_chan.header_length  = res_ff.header_length;

endmodule

/* sv/cipher_header_parser.sv */
`timescale 1ns / 1ps
// Cipher text header parser.
// req_chan carries one packet byte per transfer (data_byte, last_byte marks the
// final byte). rsp_chan carries one decoded header per packet: either the full
// header once its last field byte arrives, or a truncation report (status 1)
// when the packet ends first. Bytes after the header are dropped up to the last.
// Throughput: one byte per cycle while ready is high. Each header byte only
// lands in a field register and moves the phase and byte counters; the result
// of a byte is formed in the same cycle and held in an output register.
// Output: the result is registered and appears on rsp_chan in the cycle after
// the byte that completes (or truncates) the header.
// Stall: req_chan.ready stays high while the output register is empty or being
// drained; when the receiver holds off with a result pending, ready drops and
// no byte is taken until that result transfers.
// Reset: synchronous, active high; empties the output register and restarts
// parsing at the flag word of a new packet. Ready is low during reset.

`include "assert_macros.svh"

module cipher_header_parser (
   input  logic      clock,
   input  logic      reset,
   chp_req_if.sink   req_chan,
   chp_rsp_if.source rsp_chan
);

   chp_pkg::chp_phase_type phase_ff, phase_in;
   logic [4:0]             fcount_ff, fcount_in;
   logic [31:0]            flag_ff, flag_in;
   logic [5:0]             consumed_ff, consumed_in;
   logic [63:0]            kguid_ff[2], kguid_in[2];
   logic [63:0]            keyguid_ff[2], keyguid_in[2];
   logic [31:0]            koff_ff, koff_in;
   logic [63:0]            offset_ff, offset_in;
   logic [63:0]            length_ff, length_in;
   logic [7:0]             alg_ff, alg_in;
   logic                   skip_ff, skip_in;

   logic                    out_free;
   logic                    accept;
   logic                    emit;
   logic                    clear_pkt;
   logic [4:0]              fcount_nxt;
   logic                    internal;
   chp_pkg::chp_result_type result;

   assign req_chan.ready = out_free && !reset;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      phase_in      = phase_ff;
      fcount_in     = fcount_ff;
      flag_in       = flag_ff;
      consumed_in   = consumed_ff;
      kguid_in      = kguid_ff;
      keyguid_in    = keyguid_ff;
      koff_in       = koff_ff;
      offset_in     = offset_ff;
      length_in     = length_ff;
      alg_in        = alg_ff;
      skip_in       = skip_ff;
      emit          = 1'b0;
      clear_pkt     = 1'b0;
      result        = '0;
      fcount_nxt    = fcount_ff + 5'd1;
      internal      = 1'b0;

      if (accept) begin
         if (skip_ff || phase_ff == chp_pkg::PH_DONE) begin
            if (req_chan.last_byte) begin
               clear_pkt = 1'b1;
            end else begin
               skip_in = 1'b1;
            end
         end else begin
            if (consumed_ff < chp_pkg::COUNT_MAX) begin
               consumed_in = consumed_ff + 6'd1;
            end
            case (phase_ff)
               chp_pkg::PH_FLAGS: begin
                  flag_in[{fcount_ff[1:0], 3'b000} +: 8] = req_chan.data_byte;
               end
               chp_pkg::PH_KGUID: begin
                  kguid_in[fcount_ff[3]][{fcount_ff[2:0], 3'b000} +: 8] = req_chan.data_byte;
               end
               chp_pkg::PH_KOFF: begin
                  koff_in[{fcount_ff[1:0], 3'b000} +: 8] = req_chan.data_byte;
               end
               chp_pkg::PH_KEYGUID: begin
                  keyguid_in[fcount_ff[3]][{fcount_ff[2:0], 3'b000} +: 8] =
                     req_chan.data_byte;
               end
               chp_pkg::PH_OFFSET: begin
                  offset_in[{fcount_ff[2:0], 3'b000} +: 8] = req_chan.data_byte;
               end
               chp_pkg::PH_LENGTH: begin
                  length_in[{fcount_ff[2:0], 3'b000} +: 8] = req_chan.data_byte;
               end
               chp_pkg::PH_ALG: begin
                  alg_in = req_chan.data_byte;
               end
               default: begin
               end
            endcase

            // field complete: move to the next field the flags ask for
            if (fcount_nxt >= chp_pkg::phase_size(phase_ff, flag_in)) begin
               fcount_in = 5'd0;
               phase_in  = chp_pkg::next_phase(phase_ff, flag_in);
            end else begin
               fcount_in = fcount_nxt;
            end

            internal = (flag_in & chp_pkg::FLAG_INTERNAL) != 32'd0;

            if (phase_in == chp_pkg::PH_DONE) begin
               emit                  = 1'b1;
               result.status         = chp_pkg::STATUS_COMPLETE;
               result.is_internal    = internal;
               result.key_offset     = internal ? {48'd0, flag_in[23:8]} : offset_in;
               result.text_length    = length_in;
               result.algorithm      = alg_in;
               result.kernel_id_low  = kguid_in[0];
               result.kernel_id_high = kguid_in[1];
               result.kernel_offset  = koff_in;
               result.key_id_low     = keyguid_in[0];
               result.key_id_high    = keyguid_in[1];
               if (!internal) begin
                  result.option_bits[0] = (flag_in & chp_pkg::FLAG_DECRYPT_ONCE) != 32'd0;
                  result.option_bits[1] = (flag_in & chp_pkg::FLAG_VERIFY_KEY) != 32'd0;
                  result.option_bits[2] = (flag_in & chp_pkg::FLAG_END_CHAIN) != 32'd0;
                  result.option_bits[3] = (flag_in & chp_pkg::FLAG_TRAILER) != 32'd0;
               end
               result.header_length  = consumed_in;
               if (req_chan.last_byte) begin
                  clear_pkt = 1'b1;
               end else begin
                  skip_in = 1'b1;
               end
            end else if (req_chan.last_byte) begin
               emit                 = 1'b1;
               result.status        = chp_pkg::STATUS_TRUNCATED;
               result.header_length = consumed_in;
               clear_pkt            = 1'b1;
            end
         end
      end

      if (clear_pkt) begin
         phase_in    = chp_pkg::PH_FLAGS;
         fcount_in   = 5'd0;
         flag_in     = 32'd0;
         consumed_in = 6'd0;
         kguid_in    = '{64'd0, 64'd0};
         keyguid_in  = '{64'd0, 64'd0};
         koff_in     = 32'd0;
         offset_in   = 64'd0;
         length_in   = 64'd0;
         alg_in      = 8'd0;
         skip_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= chp_pkg::PH_FLAGS;
         fcount_ff   <= 5'd0;
         flag_ff     <= 32'd0;
         consumed_ff <= 6'd0;
         kguid_ff    <= '{64'd0, 64'd0};
         keyguid_ff  <= '{64'd0, 64'd0};
         koff_ff     <= 32'd0;
         offset_ff   <= 64'd0;
         length_ff   <= 64'd0;
         alg_ff      <= 8'd0;
         skip_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fcount_ff   <= fcount_in;
         flag_ff     <= flag_in;
         consumed_ff <= consumed_in;
         kguid_ff    <= kguid_in;
         keyguid_ff  <= keyguid_in;
         koff_ff     <= koff_in;
         offset_ff   <= offset_in;
         length_ff   <= length_in;
         alg_ff      <= alg_in;
         skip_ff     <= skip_in;
      end
   end

   chp_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (emit),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   // no field is longer than sixteen bytes
   `CHP_ASSERT_NOW(a_fcount_range, clock, reset, 1'b1, fcount_ff < 5'd16,
      "field byte count out of range")
   // the longest header is 57 bytes
   `CHP_ASSERT_NOW(a_consumed_range, clock, reset, 1'b1, consumed_ff <= 6'd57,
      "header byte count past the longest header")
   // skipping only follows a header that took at least one byte
   `CHP_ASSERT_NOW(a_skip_after_header, clock, reset, skip_ff, consumed_ff != 6'd0,
      "skipping with no header consumed")
   // a last byte always restarts the parser on a fresh packet
   `CHP_ASSERT_NEXT(a_last_restarts, clock, reset, accept && req_chan.last_byte,
      phase_ff == chp_pkg::PH_FLAGS && consumed_ff == 6'd0 && !skip_ff,
      "parser not restarted after last byte")

endmodule
